/* rtl/mandelbrot_escape_time_defines.svh */
// Assertion macros for the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`ifndef SYNTHESIS
`define MET_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mandelbrot_escape_time: check failed");
`define MET_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mandelbrot_escape_time: check failed");
`else
`define MET_ASSERT_IMP(label, ante, cons)
`define MET_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/met_pkg.sv */
package met_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int PIX_X_W = 11;
    localparam int PIX_Y_W = 10;
    localparam int COUNT_W = 17;
    localparam int RES_W = 18;
    localparam int ZOOM_W = 31;
    localparam int Q_W = 32;

    localparam logic [36:0] MAG_LIMIT = 37'd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 8'd3;

    localparam logic [COUNT_W-1:0] RST_MAX_ITER = 17'd124;
    localparam logic [ZOOM_W-1:0] RST_ZOOM = 31'd268435456;
    localparam logic [Q_W-1:0] RST_OFFSET_X = 32'hF4CC_CCCD;
    localparam logic [Q_W-1:0] RST_OFFSET_Y = 32'h0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_SQ,
        S_UPD,
        S_FIN
    } t_met_state;

    typedef struct packed {
        logic load;
        logic map;
        logic sq;
        logic upd;
        logic out_load;
    } t_met_cmd;

    typedef struct packed {
        logic c_bad;
        logic at_limit;
        logic escape;
        logic overflow;
    } t_met_stat;

endpackage

/* rtl/met_ctrl.sv */
`include "mandelbrot_escape_time_defines.svh"
module met_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  met_pkg::t_met_stat i_stat,
    output logic              o_in_ready,
    output met_pkg::t_met_cmd  o_cmd
);
    import met_pkg::*;

    t_met_state r_state;
    t_met_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                if (i_stat.c_bad || i_stat.at_limit) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.sq = 1'b1;
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                if (i_stat.escape) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = i_stat.overflow ? S_FIN : S_SQ;
                end
            end
            S_FIN: begin
                if (!i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `MET_ASSERT_NXT(a_load_then_map, o_cmd.load, o_cmd.map)
    `MET_ASSERT_IMP(a_upd_after_sq, o_cmd.upd, $past(o_cmd.sq))
    `MET_ASSERT_NXT(a_out_load_idle, o_cmd.out_load, o_in_ready)

endmodule

/* rtl/met_datapath.sv */
module met_datapath #(
    parameter int IMAGE_WIDTH  = 1500,
    parameter int IMAGE_HEIGHT = 1000
) (
    input  logic                            i_clk,
    input  met_pkg::t_met_cmd                i_cmd,
    input  logic [met_pkg::PIX_X_W-1:0]     i_pixel_x,
    input  logic [met_pkg::PIX_Y_W-1:0]     i_pixel_y,
    input  logic [met_pkg::COUNT_W-1:0]     i_max_iterations,
    input  logic [met_pkg::ZOOM_W-1:0]      i_zoom_step,
    input  logic [met_pkg::Q_W-1:0]         i_offset_x,
    input  logic [met_pkg::Q_W-1:0]         i_offset_y,
    output met_pkg::t_met_stat               o_stat,
    output logic [met_pkg::RES_W-1:0]       o_res_count,
    output logic                            o_res_in_set
);
    import met_pkg::*;

    localparam logic signed [13:0] DIM_X = 14'(IMAGE_WIDTH);
    localparam logic signed [13:0] DIM_Y = 14'(IMAGE_HEIGHT);

    logic signed [13:0] w_d2x;
    logic signed [13:0] w_d2y;
    logic signed [31:0] w_zoom_s;
    logic signed [43:0] w_prod_x;
    logic signed [43:0] w_prod_y;
    logic signed [43:0] r_prod_x;
    logic signed [43:0] r_prod_y;
    logic signed [43:0] w_off_x;
    logic signed [43:0] w_off_y;
    logic signed [43:0] w_cr_full;
    logic signed [43:0] w_ci_full;
    logic               w_c_bad;

    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic               r_c_bad;
    logic [COUNT_W-1:0] r_count;

    logic signed [63:0] r_rr_p;
    logic signed [63:0] r_ii_p;
    logic signed [63:0] r_ri_p;

    logic [35:0]        w_rr;
    logic [35:0]        w_ii;
    logic [36:0]        w_mag;
    logic signed [37:0] w_rr_s;
    logic signed [37:0] w_ii_s;
    logic signed [37:0] w_ri_s;
    logic signed [37:0] w_cr_s;
    logic signed [37:0] w_ci_s;
    logic signed [37:0] w_nr;
    logic signed [37:0] w_ni;
    logic               w_nr_ok;
    logic               w_ni_ok;
    logic               w_at_limit;

    assign w_d2x    = $signed({2'b00, i_pixel_x, 1'b0}) - DIM_X;
    assign w_d2y    = $signed({3'b000, i_pixel_y, 1'b0}) - DIM_Y;
    assign w_zoom_s = $signed({1'b0, i_zoom_step});
    assign w_prod_x = 44'(w_d2x) * 44'(w_zoom_s);
    assign w_prod_y = 44'(w_d2y) * 44'(w_zoom_s);

    assign w_off_x   = {{12{i_offset_x[31]}}, i_offset_x};
    assign w_off_y   = {{12{i_offset_y[31]}}, i_offset_y};
    assign w_cr_full = (r_prod_x >>> 1) + w_off_x;
    assign w_ci_full = (r_prod_y >>> 1) + w_off_y;
    assign w_c_bad   = !((&w_cr_full[43:31]) || !(|w_cr_full[43:31]))
                    || !((&w_ci_full[43:31]) || !(|w_ci_full[43:31]));

    assign w_rr   = r_rr_p[63:28];
    assign w_ii   = r_ii_p[63:28];
    assign w_mag  = {1'b0, w_rr} + {1'b0, w_ii};
    assign w_rr_s = {2'b00, w_rr};
    assign w_ii_s = {2'b00, w_ii};
    assign w_ri_s = {r_ri_p[63], r_ri_p[63:27]};
    assign w_cr_s = {{6{r_cr[31]}}, r_cr};
    assign w_ci_s = {{6{r_ci[31]}}, r_ci};
    assign w_nr   = w_rr_s - w_ii_s + w_cr_s;
    assign w_ni   = w_ri_s + w_ci_s;
    assign w_nr_ok = (&w_nr[37:31]) || !(|w_nr[37:31]);
    assign w_ni_ok = (&w_ni[37:31]) || !(|w_ni[37:31]);

    assign w_at_limit = (r_count == i_max_iterations);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
        if (i_cmd.map) begin
            r_cr    <= w_cr_full[31:0];
            r_ci    <= w_ci_full[31:0];
            r_zr    <= w_cr_full[31:0];
            r_zi    <= w_ci_full[31:0];
            r_c_bad <= w_c_bad;
            r_count <= '0;
        end
        if (i_cmd.sq) begin
            r_rr_p <= 64'(r_zr) * 64'(r_zr);
            r_ii_p <= 64'(r_zi) * 64'(r_zi);
            r_ri_p <= 64'(r_zr) * 64'(r_zi);
        end
        if (i_cmd.upd) begin
            r_zr    <= w_nr[31:0];
            r_zi    <= w_ni[31:0];
            r_count <= r_count + 1'b1;
        end
    end

    assign o_stat.c_bad    = r_c_bad;
    assign o_stat.at_limit = w_at_limit;
    assign o_stat.escape   = (w_mag >= MAG_LIMIT);
    assign o_stat.overflow = !(w_nr_ok && w_ni_ok);

    always_comb begin
        if (r_c_bad) begin
            o_res_count  = '0;
            o_res_in_set = 1'b0;
        end else if (w_at_limit) begin
            o_res_count  = {1'b0, r_count} + 18'd1;
            o_res_in_set = 1'b1;
        end else begin
            o_res_count  = {1'b0, r_count};
            o_res_in_set = 1'b0;
        end
    end

endmodule

/* rtl/mandelbrot_escape_time.sv */
// Escape-time evaluator: one pixel coordinate in, one iteration count out.
// Request channel: i_valid / o_ready with i_pixel_x, i_pixel_y.
// Result channel: o_valid / i_ready with o_escape_count, o_in_set.
// Register channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
// always ready, index 0 iteration limit, 1 zoom step, 2 and 3 the centre
// offsets. Write only while no request is in flight.
// One request is worked on at a time. The accepting cycle forms the pixel
// products and the next one maps them to c; each iteration then runs
// through S_SQ (the three 32x32 products) and S_UPD (the magnitude test and
// update). The result is offered when the limit is reached, on escape, when z
// leaves range or when c is out of range. The controller is ready for the
// next request in the cycle after the result is loaded.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the following result holds in the
// controller until the output register frees, and no new request is taken.
// Reset empties the output, returns the controller to idle and loads the
// register defaults (limit 124, zoom 1.0, centre -0.7 + 0i).
`include "mandelbrot_escape_time_defines.svh"
module mandelbrot_escape_time #(
    parameter int IMAGE_WIDTH  = 1500,
    parameter int IMAGE_HEIGHT = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [met_pkg::PIX_X_W-1:0]       i_pixel_x,
    input  logic [met_pkg::PIX_Y_W-1:0]       i_pixel_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [met_pkg::RES_W-1:0]         o_escape_count,
    output logic                              o_in_set,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import met_pkg::*;

    logic [COUNT_W-1:0] r_max_iterations;
    logic [ZOOM_W-1:0]  r_zoom_step;
    logic [Q_W-1:0]     r_offset_x;
    logic [Q_W-1:0]     r_offset_y;

    logic               r_valid;
    logic [RES_W-1:0]   r_escape_count;
    logic               r_in_set;

    t_met_cmd           w_cmd;
    t_met_stat          w_stat;
    logic [RES_W-1:0]   w_res_count;
    logic               w_res_in_set;
    logic               w_out_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iterations <= RST_MAX_ITER;
            r_zoom_step      <= RST_ZOOM;
            r_offset_x       <= RST_OFFSET_X;
            r_offset_y       <= RST_OFFSET_Y;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_ITER: r_max_iterations <= i_cfg_data[COUNT_W-1:0];
                CFG_ZOOM:     r_zoom_step      <= i_cfg_data[ZOOM_W-1:0];
                CFG_OFFSET_X: r_offset_x       <= i_cfg_data[Q_W-1:0];
                CFG_OFFSET_Y: r_offset_y       <= i_cfg_data[Q_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_stall = r_valid && !i_ready;

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (w_out_stall),
        .i_stat      (w_stat),
        .o_in_ready  (o_ready),
        .o_cmd       (w_cmd)
    );

    met_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_max_iterations (r_max_iterations),
        .i_zoom_step      (r_zoom_step),
        .i_offset_x       (r_offset_x),
        .i_offset_y       (r_offset_y),
        .o_stat           (w_stat),
        .o_res_count      (w_res_count),
        .o_res_in_set     (w_res_in_set)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_escape_count <= w_res_count;
            r_in_set       <= w_res_in_set;
        end
    end

    assign o_valid        = r_valid;
    assign o_escape_count = r_escape_count;
    assign o_in_set       = r_in_set;

    `MET_ASSERT_IMP(a_no_overwrite, w_cmd.out_load, !r_valid || i_ready)
    `MET_ASSERT_IMP(a_in_set_count, r_valid && r_in_set, r_escape_count != '0)
    `MET_ASSERT_NXT(a_valid_hold, o_valid && !i_ready, o_valid)

endmodule
